[design/bmpenc_pkg.sv]
// ----------------------------------------------------------------------------
// bmpenc_pkg
// Shared types, constants and field widths of the RGB565 to BMP stream encoder.
// ----------------------------------------------------------------------------
package bmpenc_pkg;

  // Largest frame dimension. Larger register values are clamped to it.
  localparam int unsigned MAX_DIM  = 1024;

  localparam int unsigned DIM_W    = 11;   // img_width / img_height registers
  localparam int unsigned PIX_W    = 16;   // RGB565 pixel
  localparam int unsigned WORD_W   = 32;   // output word
  localparam int unsigned CNT_W    = 3;    // valid bytes in a word
  localparam int unsigned STRIDE_W = 12;   // padded row length in bytes
  localparam int unsigned SIZE_W   = 22;   // pixel array length in bytes
  localparam int unsigned DATA_W   = 24;   // pixel bytes carried in a command
  localparam int unsigned NBYTE_W  = 3;    // pixel plus padding bytes, up to six

  // Command queue between the front and back parts.
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W    = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MODE   = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd240;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd240;

  // Input action codes.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  // Output modes.
  localparam logic MODE_BF16  = 1'b0;
  localparam logic MODE_RGB24 = 1'b1;

  // BMP header fields.
  localparam int unsigned HDR_LEN_BF16    = 70;
  localparam int unsigned HDR_LEN_RGB24   = 54;
  localparam int unsigned HDR_WORDS_BF16  = HDR_LEN_BF16 / 4;
  localparam int unsigned HDR_WORDS_RGB24 = HDR_LEN_RGB24 / 4;
  localparam int unsigned HDR_TAIL_BYTES  = HDR_LEN_BF16 % 4;
  localparam int unsigned INFO_LEN        = 40;
  localparam int unsigned COMPR_RGB       = 0;
  localparam int unsigned COMPR_BITFIELDS = 3;
  localparam logic [WORD_W-1:0] MASK_RED   = 32'h0000_F800;
  localparam logic [WORD_W-1:0] MASK_GREEN = 32'h0000_07E0;
  localparam logic [WORD_W-1:0] MASK_BLUE  = 32'h0000_001F;

  typedef enum logic {
    CMD_HEADER,
    CMD_PIXEL
  } cmd_kind_e;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             mode;
  } cfg_t;

  // One classified item on its way from the front part to the back part.
  typedef struct packed {
    cmd_kind_e          kind;
    logic               mode;        // header: latched output mode
    logic [DIM_W-1:0]   width;       // header: clamped width
    logic [DIM_W-1:0]   height;      // header: clamped height
    logic [SIZE_W-1:0]  image_size;  // header: pixel array bytes
    logic [DATA_W-1:0]  data;        // pixel: bytes, first in the low bits
    logic [NBYTE_W-1:0] nbytes;      // pixel: data bytes plus row padding
    logic               frame_done;  // pixel: last pixel of the frame
  } cmd_t;

endpackage

[design/bmpenc_in_if.sv]
// ----------------------------------------------------------------------------
// bmpenc_in_if
// Input channel of the encoder: a frame start or one RGB565 pixel per beat.
// ----------------------------------------------------------------------------
interface bmpenc_in_if;
  import bmpenc_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output action, output pixel, input ready);
  modport sink   (input valid, input action, input pixel, output ready);
endinterface

[design/bmpenc_out_if.sv]
// ----------------------------------------------------------------------------
// bmpenc_out_if
// Output channel of the encoder: one little-endian word of the BMP file per beat.
// ----------------------------------------------------------------------------
interface bmpenc_out_if;
  import bmpenc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic [CNT_W-1:0]  byte_count;
  logic              run_last;
  logic              frame_end;

  modport source (output valid, output word, output byte_count, output run_last,
                  output frame_end, input ready);
  modport sink   (input valid, input word, input byte_count, input run_last,
                  input frame_end, output ready);
endinterface

[design/bmpenc_front.sv]
// ----------------------------------------------------------------------------
// bmpenc_front
// Accepts input beats, tracks the frame position and turns each start beat and
// each pixel beat inside a frame into a header or pixel command for the back part.
// ----------------------------------------------------------------------------
module bmpenc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  bmpenc_in_if.sink          in_i,
  input  bmpenc_pkg::cfg_t   cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output bmpenc_pkg::cmd_t   cmd_o
);
  import bmpenc_pkg::*;

  // A dimension of zero acts as one, any above the maximum as the maximum.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if ({1'b0, v} > (DIM_W + 1)'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  // (x*255+15)/31, the division done as a multiply by a rounded-up reciprocal.
  function automatic logic [7:0] expand5(input logic [4:0] x);
    logic [12:0] n;
    logic [26:0] p;
    n = ({8'd0, x} << 8) - {8'd0, x} + 13'd15;
    p = 27'(n) * 27'd8457;
    return p[25:18];
  endfunction

  // (x*255+31)/63, same scheme with a 20-bit reciprocal.
  function automatic logic [7:0] expand6(input logic [5:0] x);
    logic [13:0] n;
    logic [28:0] p;
    n = ({8'd0, x} << 8) - {8'd0, x} + 14'd31;
    p = 29'(n) * 29'd16645;
    return p[27:20];
  endfunction

  logic                in_frame_q, in_frame_d;
  logic                mode_q, mode_d;
  logic [DIM_W-1:0]    col_q, col_d;
  logic [DIM_W-1:0]    row_q, row_d;

  logic                accept;
  logic [DIM_W-1:0]    w_eff, h_eff;
  logic [STRIDE_W-1:0] w_p1, w_x3, stride;
  logic [SIZE_W:0]     size_prod;
  logic [DIM_W:0]      col_p1, row_p1;
  logic                row_end, last_row;
  logic [NBYTE_W-1:0]  pad;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  always_comb begin
    w_eff     = eff_dim(cfg_i.width);
    h_eff     = eff_dim(cfg_i.height);
    // Padded row length: 2 bytes or 3 bytes a pixel, rounded up to four.
    w_p1      = {1'b0, w_eff} + STRIDE_W'(1);
    w_x3      = ({1'b0, w_eff} << 1) + {1'b0, w_eff} + STRIDE_W'(3);
    stride    = (cfg_i.mode == MODE_RGB24) ? {w_x3[STRIDE_W-1:2], 2'b00}
                                           : {w_p1[STRIDE_W-2:1], 2'b00};
    size_prod = (SIZE_W + 1)'(stride) * (SIZE_W + 1)'(h_eff);

    col_p1    = {1'b0, col_q} + (DIM_W + 1)'(1);
    row_p1    = {1'b0, row_q} + (DIM_W + 1)'(1);
    row_end   = col_p1 >= {1'b0, w_eff};
    last_row  = row_p1 >= {1'b0, h_eff};

    // Row padding: 16-bit rows lack two bytes for odd widths, 24-bit rows
    // lack (width mod 4) bytes.
    pad = '0;
    if (row_end) begin
      if (mode_q == MODE_RGB24) begin
        pad = NBYTE_W'(w_eff[1:0]);
      end else if (w_eff[0]) begin
        pad = NBYTE_W'(2);
      end
    end

    cmd_o            = '0;
    cmd_o.mode       = cfg_i.mode;
    cmd_o.width      = w_eff;
    cmd_o.height     = h_eff;
    cmd_o.image_size = size_prod[SIZE_W-1:0];
    cmd_o.frame_done = row_end && last_row;
    if (in_i.action == ACT_START) begin
      cmd_o.kind = CMD_HEADER;
    end else begin
      cmd_o.kind = CMD_PIXEL;
    end
    if (mode_q == MODE_RGB24) begin
      cmd_o.data   = {expand5(in_i.pixel[15:11]), expand6(in_i.pixel[10:5]),
                      expand5(in_i.pixel[4:0])};
      cmd_o.nbytes = NBYTE_W'(3) + pad;
    end else begin
      cmd_o.data   = {8'd0, in_i.pixel};
      cmd_o.nbytes = NBYTE_W'(2) + pad;
    end

    push_o = accept && ((in_i.action == ACT_START) || in_frame_q);

    in_frame_d = in_frame_q;
    mode_d     = mode_q;
    col_d      = col_q;
    row_d      = row_q;
    if (accept) begin
      if (in_i.action == ACT_START) begin
        in_frame_d = 1'b1;
        mode_d     = cfg_i.mode;
        col_d      = '0;
        row_d      = '0;
      end else if (in_frame_q) begin
        if (row_end) begin
          col_d = '0;
          if (last_row) begin
            row_d      = '0;
            in_frame_d = 1'b0;
          end else begin
            row_d = row_p1[DIM_W-1:0];
          end
        end else begin
          col_d = col_p1[DIM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      mode_q     <= MODE_BF16;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      mode_q     <= mode_d;
      col_q      <= col_d;
      row_q      <= row_d;
    end
  end

endmodule

[design/bmpenc_queue.sv]
// ----------------------------------------------------------------------------
// bmpenc_queue
// Short command queue that lets the front and back parts stall independently.
// ----------------------------------------------------------------------------
module bmpenc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bmpenc_pkg::cmd_t   cmd_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output bmpenc_pkg::cmd_t   head_o
);
  import bmpenc_pkg::*;

  cmd_t              slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = cnt_q == (QPTR_W + 1)'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command popped from an empty queue");

  a_fill_tracks_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue fill level did not follow a push");

endmodule

[design/bmpenc_back.sv]
// ----------------------------------------------------------------------------
// bmpenc_back
// Carries out header and pixel commands: packs bytes into words and drives
// the registered output channel, one word per cycle while the receiver takes them.
// ----------------------------------------------------------------------------
module bmpenc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  bmpenc_pkg::cmd_t   head_i,
  output logic               pop_o,
  bmpenc_out_if.source       out_o
);
  import bmpenc_pkg::*;

  localparam int unsigned HDR_BITS = (HDR_WORDS_BF16 + 1) * WORD_W;
  localparam int unsigned BUF_BITS = 3 * WORD_W;

  logic [4:0]          step_q, step_d;
  logic [DATA_W-1:0]   pend_q, pend_d;
  logic [1:0]          pcnt_q, pcnt_d;

  logic                ovalid_q, ovalid_d;
  logic [WORD_W-1:0]   oword_q, oword_d;
  logic [CNT_W-1:0]    ocnt_q, ocnt_d;
  logic                olast_q, olast_d;
  logic                oend_q, oend_d;

  logic                adv;
  logic [HDR_BITS-1:0] hv;
  logic [WORD_W-1:0]   hdr_len, total_len;
  logic [4:0]          hdr_words;
  logic                hdr_last;

  logic [BUF_BITS-1:0] pbuf;
  logic [3:0]          ptot;
  logic [1:0]          pfull, prem, pwords;
  logic [DATA_W-1:0]   ptail;
  logic                pix_last;

  always_comb begin
    // Header image for the current command; only its first words are sent.
    hdr_len   = (head_i.mode == MODE_RGB24) ? WORD_W'(HDR_LEN_RGB24)
                                            : WORD_W'(HDR_LEN_BF16);
    hdr_words = (head_i.mode == MODE_RGB24) ? 5'(HDR_WORDS_RGB24)
                                            : 5'(HDR_WORDS_BF16);
    total_len = hdr_len + WORD_W'(head_i.image_size);
    hv            = '0;
    hv[7:0]       = 8'h42;
    hv[15:8]      = 8'h4D;
    hv[47:16]     = total_len;
    hv[111:80]    = hdr_len;
    hv[143:112]   = WORD_W'(INFO_LEN);
    hv[175:144]   = WORD_W'(head_i.width);
    hv[207:176]   = WORD_W'(head_i.height);
    hv[215:208]   = 8'd1;
    hv[231:224]   = (head_i.mode == MODE_RGB24) ? 8'd24 : 8'd16;
    hv[271:240]   = (head_i.mode == MODE_RGB24) ? WORD_W'(COMPR_RGB)
                                                : WORD_W'(COMPR_BITFIELDS);
    hv[303:272]   = WORD_W'(head_i.image_size);
    if (head_i.mode == MODE_BF16) begin
      hv[463:432] = MASK_RED;
      hv[495:464] = MASK_GREEN;
      hv[527:496] = MASK_BLUE;
    end
    hdr_last = step_q == (hdr_words - 5'd1);

    // Pending bytes followed by the new pixel bytes; padding bytes are zero.
    pbuf     = BUF_BITS'(pend_q) | (BUF_BITS'(head_i.data) << {pcnt_q, 3'b000});
    ptot     = 4'(pcnt_q) + 4'(head_i.nbytes);
    pfull    = ptot[3:2];
    prem     = ptot[1:0];
    pwords   = pfull + 2'(head_i.frame_done && (prem != 2'd0));
    ptail    = pbuf[{pfull, 5'd0} +: DATA_W];
    pix_last = step_q[1:0] == (pwords - 2'd1);

    step_d   = step_q;
    pend_d   = pend_q;
    pcnt_d   = pcnt_q;
    ovalid_d = ovalid_q;
    oword_d  = oword_q;
    ocnt_d   = ocnt_q;
    olast_d  = olast_q;
    oend_d   = oend_q;
    pop_o    = 1'b0;

    adv = !ovalid_q || out_o.ready;
    if (adv) begin
      ovalid_d = 1'b0;
    end

    if (valid_i && adv) begin
      unique case (head_i.kind)
        CMD_HEADER: begin
          ovalid_d = 1'b1;
          oword_d  = hv[{step_q, 5'd0} +: WORD_W];
          ocnt_d   = CNT_W'(4);
          olast_d  = hdr_last;
          oend_d   = 1'b0;
          if (hdr_last) begin
            // The two header bytes that do not fill a word are zero.
            pop_o  = 1'b1;
            step_d = '0;
            pend_d = '0;
            pcnt_d = 2'(HDR_TAIL_BYTES);
          end else begin
            step_d = step_q + 5'd1;
          end
        end
        CMD_PIXEL: begin
          if (pwords == 2'd0) begin
            pop_o  = 1'b1;
            pend_d = ptail;
            pcnt_d = prem;
          end else begin
            ovalid_d = 1'b1;
            oword_d  = pbuf[{step_q[1:0], 5'd0} +: WORD_W];
            ocnt_d   = (step_q[1:0] < pfull) ? CNT_W'(4) : CNT_W'(prem);
            olast_d  = pix_last;
            oend_d   = pix_last && head_i.frame_done;
            if (pix_last) begin
              pop_o  = 1'b1;
              step_d = '0;
              pend_d = head_i.frame_done ? '0 : ptail;
              pcnt_d = head_i.frame_done ? 2'd0 : prem;
            end else begin
              step_d = step_q + 5'd1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      pend_q   <= '0;
      pcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      pend_q   <= pend_d;
      pcnt_q   <= pcnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oword_q <= oword_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
    oend_q  <= oend_d;
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.word       = oword_q;
  assign out_o.byte_count = ocnt_q;
  assign out_o.run_last   = olast_q;
  assign out_o.frame_end  = oend_q;

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oend_q) |-> olast_q)
    else $error("frame end flagged on a word that does not close its item");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> ((ocnt_q != '0) && (ocnt_q <= CNT_W'(4))))
    else $error("output word carries an impossible byte count");

  a_step_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (step_q == '0))
    else $error("word step not cleared after a command completed");

endmodule

[design/rgb565_bmp_stream_encoder.sv]
// ----------------------------------------------------------------------------
// rgb565_bmp_stream_encoder
// Converts a frame of RGB565 pixels into a BMP file streamed as 32-bit words.
// ----------------------------------------------------------------------------
// A start beat (action 0) latches the output mode and sends the file header:
// 70 bytes with bit-field compression masks F800/07E0/001F in 16-bit mode, or
// 54 bytes uncompressed in 24-bit mode. Each pixel beat (action 1) then adds
// two raw bytes, or three bytes B, G, R expanded to eight bits with rounding;
// each row is zero-padded to a multiple of four bytes, and after the last
// pixel any partial word is flushed with frame_end set. Bytes are packed
// little-endian, first byte in bits 7-0, and byte_count gives the valid bytes
// of each word. Pixels must arrive bottom row first; pixel beats outside a
// frame are dropped and a start beat during a frame abandons it. Widths and
// heights of zero act as one and values above 1024 act as 1024. Timing: the
// input side takes one beat per cycle while the four-entry command queue has
// room. While the receiver is ready, the output side sends one word per cycle:
// a header is 17 words (16-bit) or 13 words (24-bit), a pixel gives zero to
// three words and leaves the queue without output when it gives none.
// Sustained throughput with a ready receiver is one pixel a cycle, except
// where a 24-bit pixel closing a padded row gives two words, or the last
// pixel of a frame up to three; the queue soaks up these short bursts.
// Configuration writes are taken at any clock edge and should be made while
// no beat is in flight. Size changes during a frame act from the next pixel
// beat on; a mode change waits for the next start beat.
// ----------------------------------------------------------------------------
module rgb565_bmp_stream_encoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bmpenc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bmpenc_pkg::DIM_W-1:0]         cfg_wdata_i,
  bmpenc_in_if.sink                            in_i,
  bmpenc_out_if.source                         out_o
);
  import bmpenc_pkg::*;

  // Configuration registers; the front part reads them when it classifies a
  // beat, so the header and row counting always see the current values.
  cfg_t cfg_q;

  logic push;
  logic full;
  logic pop;
  logic head_valid;
  cmd_t cmd;
  cmd_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= WIDTH_RESET;
      cfg_q.height <= HEIGHT_RESET;
      cfg_q.mode   <= MODE_BF16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMG_WIDTH:  cfg_q.width  <= cfg_wdata_i;
        CFG_IMG_HEIGHT: cfg_q.height <= cfg_wdata_i;
        CFG_OUT_MODE:   cfg_q.mode   <= cfg_wdata_i[0];
        default: begin
          // Unused index: the write is ignored.
        end
      endcase
    end
  end

  // Front part: frame tracking, pixel expansion, padding and header sizing.
  bmpenc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd)
  );

  // Command queue decoupling the input side from the word packer.
  bmpenc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  // Back part: byte packing, header generation and the output register.
  bmpenc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

[sim/rgb565_bmp_stream_encoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_bmp_stream_encoder_tb
// Self-checking bench for the RGB565 to BMP stream encoder. A scoreboard class
// predicts every word of each BMP file from the accepted input beats and the
// register writes. Each output beat is compared with the oldest prediction.
// The stimulus is a short directed sequence, then random frames under several
// idle and stall patterns.
// ----------------------------------------------------------------------------
module rgb565_bmp_stream_encoder_tb;
  import bmpenc_pkg::*;

  localparam int          HALF_PERIOD_NS = 6;     // 12 ns clock
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned RANDOM_ITEMS   = 400;   // beats in the random part, all phases
  localparam int unsigned REPORT_LIMIT   = 10;    // mismatches printed in full
  // A beat that makes no word may still be working its way through the
  // four-deep command queue when the last predicted word has arrived. The
  // wait covers the queue plus a header's worth of words.
  localparam int unsigned DRAIN_CYCLES   = 40;
  // Longest legal stretch without any beat on either channel: a run of sender
  // idles or receiver stalls at 72 % or the drain wait before a register
  // write. The limit is taken many times over that.
  localparam int unsigned STALL_LIMIT    = 3000;

  // One word of the BMP file as it leaves the encoder.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  byte_count;
    logic              run_last;
    logic              frame_end;
  } bmp_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: a bit-exact model of the encoder plus the queue of words that
  // are still owed by the block.
  // --------------------------------------------------------------------------
  class bmp_stream_scoreboard;
    // Register copies, as written through the configuration port.
    logic [DIM_W-1:0] reg_width;
    logic [DIM_W-1:0] reg_height;
    logic             reg_mode;
    // Encoder state.
    logic [23:0]      held_bytes;    // bytes waiting for a full word
    int unsigned      held_count;
    int unsigned      col_pos;
    int unsigned      row_pos;
    bit               framing;
    logic             frame_mode;    // mode taken at the start beat
    // Words made by the current beat, then the words still owed.
    bmp_word_t        batch[$];
    bmp_word_t        expected_words[$];
    int unsigned      mismatches;

    function new();
      reg_width  = WIDTH_RESET;
      reg_height = HEIGHT_RESET;
      reg_mode   = MODE_BF16;
      held_bytes = '0;
      held_count = 0;
      col_pos    = 0;
      row_pos    = 0;
      framing    = 1'b0;
      frame_mode = MODE_BF16;
      mismatches = 0;
    endfunction

    // Zero acts as one and anything above the maximum is clamped to it.
    function int unsigned dim_eff(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function int unsigned row_bytes(int unsigned w, logic m);
      int unsigned bits;
      bits = (m == MODE_RGB24) ? 24 : 16;
      return ((w * bits + 31) / 32) * 4;
    endfunction

    // Rounded expansion to eight bits: full is 31 for red and blue, 63 for green.
    function logic [7:0] widen(int unsigned x, int unsigned full);
      return 8'((x * 255 + full / 2) / full);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      case (idx)
        CFG_IMG_WIDTH:  reg_width  = val;
        CFG_IMG_HEIGHT: reg_height = val;
        CFG_OUT_MODE:   reg_mode   = val[0];
        default: ;
      endcase
    endfunction

    function void add_word(logic [WORD_W-1:0] w, logic [CNT_W-1:0] n);
      bmp_word_t e;
      e.word       = w;
      e.byte_count = n;
      e.run_last   = 1'b0;
      e.frame_end  = 1'b0;
      batch.push_back(e);
    endfunction

    function void put_byte(logic [7:0] b);
      if (held_count == 3) begin
        add_word({b, held_bytes}, CNT_W'(4));
        held_bytes = '0;
        held_count = 0;
      end else begin
        held_bytes[8*held_count +: 8] = b;
        held_count++;
      end
    endfunction

    function void emit_header();
      logic [8*HDR_LEN_BF16-1:0] hdr;
      int unsigned w;
      int unsigned ht;
      int unsigned hlen;
      int unsigned pix;
      int unsigned i;
      w    = dim_eff(reg_width);
      ht   = dim_eff(reg_height);
      hlen = (frame_mode == MODE_RGB24) ? HDR_LEN_RGB24 : HDR_LEN_BF16;
      pix  = row_bytes(w, frame_mode) * ht;
      hdr  = '0;
      hdr[0 +: 16]    = 16'h4D42;                 // signature "BM"
      hdr[8*2 +: 32]  = hlen + pix;               // file size
      hdr[8*10 +: 32] = hlen;                     // offset of the pixel array
      hdr[8*14 +: 32] = INFO_LEN;
      hdr[8*18 +: 32] = w;
      hdr[8*22 +: 32] = ht;
      hdr[8*26 +: 16] = 16'd1;                    // planes
      hdr[8*28 +: 16] = (frame_mode == MODE_RGB24) ? 16'd24 : 16'd16;
      hdr[8*30 +: 32] = (frame_mode == MODE_RGB24) ? COMPR_RGB : COMPR_BITFIELDS;
      hdr[8*34 +: 32] = pix;
      if (frame_mode == MODE_BF16) begin
        hdr[8*54 +: 32] = MASK_RED;
        hdr[8*58 +: 32] = MASK_GREEN;
        hdr[8*62 +: 32] = MASK_BLUE;
      end
      for (i = 0; i < hlen; i++) put_byte(hdr[8*i +: 8]);
    endfunction

    // Called for every accepted input beat.
    function void note_beat(logic act, logic [PIX_W-1:0] px);
      int unsigned w;
      int unsigned ht;
      int unsigned nb;
      int unsigned p;
      bit          last;
      bmp_word_t   tail;
      batch.delete();
      last = 1'b0;
      if (act == ACT_START) begin
        // A start also abandons any frame in progress with its unsent bytes.
        held_bytes = '0;
        held_count = 0;
        col_pos    = 0;
        row_pos    = 0;
        frame_mode = reg_mode;
        framing    = 1'b1;
        emit_header();
      end else begin
        if (!framing) return;
        // Row and frame ends follow the registers as they are now.
        w  = dim_eff(reg_width);
        ht = dim_eff(reg_height);
        if (frame_mode == MODE_RGB24) begin
          put_byte(widen(px[4:0], 31));
          put_byte(widen(px[10:5], 63));
          put_byte(widen(px[15:11], 31));
          nb = 3;
        end else begin
          put_byte(px[7:0]);
          put_byte(px[15:8]);
          nb = 2;
        end
        if (col_pos + 1 >= w) begin
          for (p = w * nb; p < row_bytes(w, frame_mode); p++) put_byte(8'h00);
          col_pos = 0;
          if (row_pos + 1 >= ht) begin
            last    = 1'b1;
            row_pos = 0;
          end else begin
            row_pos = (row_pos + 1) & 32'h7FF;
          end
        end else begin
          col_pos = (col_pos + 1) & 32'h7FF;
        end
        if (last) begin
          if (held_count > 0) begin
            add_word({8'h00, held_bytes}, CNT_W'(held_count));
            held_bytes = '0;
            held_count = 0;
          end
          framing = 1'b0;
        end
      end
      if (batch.size() != 0) begin
        tail = batch.pop_back();
        tail.run_last  = 1'b1;
        tail.frame_end = last;
        batch.push_back(tail);
      end
      foreach (batch[i]) expected_words.push_back(batch[i]);
    endfunction

    // Called for every accepted output beat.
    function void check_word(bmp_word_t got);
      bmp_word_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] unexpected word %08h count %0d last %0b end %0b", $time,
                   got.word, got.byte_count, got.run_last, got.frame_end);
        return;
      end
      want = expected_words.pop_front();
      if (got.word !== want.word || got.byte_count !== want.byte_count ||
          got.run_last !== want.run_last || got.frame_end !== want.frame_end) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] word mismatch: expected %08h/%0d/%0b/%0b got %08h/%0d/%0b/%0b",
                   $time, want.word, want.byte_count, want.run_last, want.frame_end,
                   got.word, got.byte_count, got.run_last, got.frame_end);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself
  // --------------------------------------------------------------------------
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = CFG_IMG_WIDTH;
  logic [DIM_W-1:0]     cfg_wdata_i = '0;

  bmpenc_in_if  in_ch ();
  bmpenc_out_if out_ch ();

  rgb565_bmp_stream_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  bmp_stream_scoreboard sb = new();

  // Percentages that set how often the sender idles and the receiver stalls;
  // each test phase sets its own pair.
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned phase_items;
  int unsigned quiet_cycles  = 0;
  int unsigned ph;
  bmp_word_t   out_beat;

  always #(HALF_PERIOD_NS) clk_i = ~clk_i;

  // The receiver decides at each falling edge whether it takes a beat at the
  // next rising edge.
  always @(negedge clk_i) begin
    out_ch.ready = ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Both channels are sampled at the rising edge. An input beat is noted
  // before any output beat of the same edge is checked, although the block's
  // latency keeps the two apart in any case. The same process watches for a
  // run of cycles in which nothing moves at all.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) sb.note_beat(in_ch.action, in_ch.pixel);
      if (out_ch.valid && out_ch.ready) begin
        out_beat.word       = out_ch.word;
        out_beat.byte_count = out_ch.byte_count;
        out_beat.run_last   = out_ch.run_last;
        out_beat.frame_end  = out_ch.frame_end;
        sb.check_word(out_beat);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks. Every task starts by waiting for a falling edge, so valid
  // of a beat that has just been taken is replaced exactly once per edge.
  // --------------------------------------------------------------------------

  // Offers one beat, idling first at the phase's rate, and returns once the
  // beat has been taken.
  task automatic send_beat(logic act, logic [PIX_W-1:0] px);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.action = act;
    in_ch.pixel  = px;
    in_ch.valid  = 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Stops offering beats and waits until the block has nothing left to give.
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    sb.set_reg(idx, val);
  endtask

  // Writes the registers picked by sel (width, height, mode), back to back,
  // and only ever while the block is quiet.
  task automatic configure(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic m,
                           logic [2:0] sel);
    if (sel[0]) write_reg(CFG_IMG_WIDTH, w);
    if (sel[1]) write_reg(CFG_IMG_HEIGHT, h);
    if (sel[2]) write_reg(CFG_OUT_MODE, DIM_W'(m));
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mostly small sizes so that frames complete; now and then an extreme or a
  // value anywhere in the register's range.
  function automatic logic [DIM_W-1:0] pick_dim(int unsigned typical);
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return DIM_W'(MAX_DIM);
      2:       return DIM_W'(MAX_DIM + 1);
      3:       return '1;
      4:       return DIM_W'($urandom);
      default: return DIM_W'($urandom_range(1, typical));
    endcase
  endfunction

  // One random frame: sometimes new sizes and mode first, then a start beat
  // and the pixels. Large frames, and a tenth of the others, are cut short
  // and left to be abandoned by the next start. A complete frame is now and
  // then followed by a stray pixel, which the block must drop.
  task automatic random_frame();
    int unsigned area;
    int unsigned n_pix;
    int unsigned k;
    bit          broken;
    if ($urandom_range(0, 99) < 55) begin
      settle();
      configure(pick_dim(8), pick_dim(3),
                $urandom_range(0, 1) ? MODE_RGB24 : MODE_BF16, 3'($urandom_range(1, 7)));
    end
    area   = sb.dim_eff(sb.reg_width) * sb.dim_eff(sb.reg_height);
    broken = (area > 48) || ($urandom_range(0, 99) < 10);
    n_pix  = broken ? $urandom_range(0, (area > 12) ? 12 : area - 1) : area;
    send_beat(ACT_START, PIX_W'($urandom));
    phase_items++;
    for (k = 0; k < n_pix; k++) begin
      send_beat(ACT_PIXEL, PIX_W'($urandom));
      phase_items++;
    end
    if (!broken && $urandom_range(0, 99) < 10) send_beat(ACT_PIXEL, PIX_W'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_START;
    in_ch.pixel  = '0;
    out_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. A pixel before any frame has started is dropped.
    send_beat(ACT_PIXEL, 16'hA5A5);
    // Frame at the reset sizes, 240 by 240 in 16-bit mode; only the header
    // and a few pixels are sent before the sizes change underneath it.
    send_beat(ACT_START, 16'h0000);
    send_beat(ACT_PIXEL, 16'h0000);
    send_beat(ACT_PIXEL, 16'hFFFF);
    send_beat(ACT_PIXEL, 16'h5A5A);
    // Width shrinks to three while the column already stands past it, so the
    // next pixel closes the row, and a height of one closes the frame. The
    // mode written here must not touch the running frame.
    settle();
    configure(11'd3, 11'd1, MODE_RGB24, 3'b111);
    send_beat(ACT_PIXEL, 16'h8001);
    send_beat(ACT_PIXEL, 16'h1234);           // after the frame: dropped
    // 24-bit frame of pure red, green and blue, one row with padding.
    send_beat(ACT_START, 16'hFFFF);
    send_beat(ACT_PIXEL, 16'hF800);
    send_beat(ACT_PIXEL, 16'h07E0);
    send_beat(ACT_PIXEL, 16'h001F);
    // A start in the middle of a frame abandons it, bytes held back included.
    send_beat(ACT_START, 16'h0000);
    send_beat(ACT_PIXEL, 16'hFFFF);
    send_beat(ACT_START, 16'h0000);
    send_beat(ACT_PIXEL, 16'h0000);
    send_beat(ACT_PIXEL, 16'h8410);
    send_beat(ACT_PIXEL, 16'hFFFF);
    // Out-of-range sizes: zero acts as one, anything above the maximum is
    // clamped, in the header as in the counting.
    settle();
    configure(11'd0, 11'h7FF, MODE_BF16, 3'b111);
    send_beat(ACT_START, 16'h0000);
    send_beat(ACT_PIXEL, 16'h7BEF);
    settle();
    configure(11'h7FF, 11'd0, MODE_RGB24, 3'b111);
    send_beat(ACT_START, 16'h0000);
    // Smallest frame: a single 16-bit pixel padded to four bytes.
    settle();
    configure(11'd1, 11'd1, MODE_BF16, 3'b111);
    send_beat(ACT_START, 16'h0000);
    send_beat(ACT_PIXEL, 16'hFFFF);

    // Random part, in four phases: no idling, a slow sender, a slow
    // receiver, and light idling on both sides.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 72;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 72;
        end
        default: begin
          src_idle_pct  = 6;
          snk_stall_pct = 6;
        end
      endcase
      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / 4) random_frame();
    end

    settle();
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
